// ----- src/ssh1_packet_deframer_defines.svh -----
// assertion macros for the ssh1 packet deframer
`ifndef SSH1_PACKET_DEFRAMER_DEFINES_SVH
`define SSH1_PACKET_DEFRAMER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SSH1PD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssh1pd assertion failed");
// next-cycle implication
`define SSH1PD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssh1pd assertion failed");
`else
`define SSH1PD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSH1PD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/ssh1pd_pkg.sv -----
// shared types, constants and crc function for the ssh1 packet deframer
`default_nettype none
package ssh1pd_pkg;

   localparam int LENGTH_WIDTH_DEF  = 19;
   localparam int QUEUE_DEPTH_DEF   = 2;
   localparam int MAX_LENGTH_RESET  = 256 * 1024;
   localparam int DEBUG_TYPE_RESET  = 36;
   localparam int IGNORE_TYPE_RESET = 32;
   localparam int PAD_BLOCK         = 8;
   localparam int WORD_BYTES        = 4;
   localparam int MIN_LENGTH        = 5;
   localparam int CSR_ADDR_WIDTH    = 4;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_MAX_LENGTH  = 2'd0;
   localparam logic [1:0] REG_DEBUG_TYPE  = 2'd1;
   localparam logic [1:0] REG_IGNORE_TYPE = 2'd2;

   // front-end phases
   localparam logic [2:0] PH_LEN  = 3'd0;
   localparam logic [2:0] PH_PAD  = 3'd1;
   localparam logic [2:0] PH_TYPE = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_CRC  = 3'd4;

   // work codes handed from front to back
   localparam logic [1:0] OP_CRC = 2'd0;
   localparam logic [1:0] OP_CHK = 2'd1;
   localparam logic [1:0] OP_ERR = 2'd2;

   // end item status codes
   localparam logic [1:0] ST_GOOD      = 2'd0;
   localparam logic [1:0] ST_CRC_ERR   = 2'd1;
   localparam logic [1:0] ST_TOO_LONG  = 2'd2;
   localparam logic [1:0] ST_TOO_SHORT = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       emit;
      logic       is_type;
      logic       last;
      logic       drop;
      logic [1:0] status;
   } op_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_is_type;
      logic       end_of_packet;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic       halted;
      logic [2:0] phase;
   } front_stat_type;

   // one byte of reflected crc-32, lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- src/ssh1_packet_deframer.sv -----
// ssh1 packet deframer: takes one byte per cycle while the work queue is not full, one result item per cycle at most
// with the queues empty, a byte's result passes through the work queue and then the result queue before the rsp ports
// throughput: one byte per cycle while the work queue is not full, set by the front state machine and the back crc unit
// the work queue and the result queue let either side stall without stopping the other
// reset: synchronous, clears framing state, queues, crc and config to reset values
`default_nettype none
`include "ssh1_packet_deframer_defines.svh"
module ssh1_packet_deframer #(
   parameter int LENGTH_WIDTH = ssh1pd_pkg::LENGTH_WIDTH_DEF,
   parameter int QUEUE_DEPTH  = ssh1pd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic [7:0]                            req_rx_byte,
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic [7:0]                                 rsp_out_byte,
   output logic                                       rsp_byte_is_type,
   output logic                                       rsp_end_of_packet,
   output logic [1:0]                                 rsp_status,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [ssh1pd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [ssh1pd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [ssh1pd_pkg::CSR_DATA_WIDTH-1:0]      prdata,
   output logic                                       pready
);

   localparam int OPW  = $bits(ssh1pd_pkg::op_type);
   localparam int RSPW = $bits(ssh1pd_pkg::rsp_type);

   logic [LENGTH_WIDTH-1:0] max_length_ff, max_length_in;
   logic [7:0]              debug_type_ff, debug_type_in;
   logic [7:0]              ignore_type_ff, ignore_type_in;
   logic                    csr_wr;
   logic [1:0]              csr_index;

   logic                       accept;
   logic                       op_push, op_full, op_empty, op_pop;
   ssh1pd_pkg::op_type         op_wr, op_rd;
   ssh1pd_pkg::front_stat_type front_stat;
   logic                       res_push, res_full;
   ssh1pd_pkg::rsp_type        res_wr, res_rd;

   // register file
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      max_length_in  = max_length_ff;
      debug_type_in  = debug_type_ff;
      ignore_type_in = ignore_type_ff;
      if (csr_wr) begin
         case (csr_index)
            ssh1pd_pkg::REG_MAX_LENGTH:  max_length_in  = pwdata[LENGTH_WIDTH-1:0];
            ssh1pd_pkg::REG_DEBUG_TYPE:  debug_type_in  = pwdata[7:0];
            ssh1pd_pkg::REG_IGNORE_TYPE: ignore_type_in = pwdata[7:0];
            default:                     max_length_in  = max_length_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ssh1pd_pkg::REG_MAX_LENGTH:  prdata = ssh1pd_pkg::CSR_DATA_WIDTH'(max_length_ff);
         ssh1pd_pkg::REG_DEBUG_TYPE:  prdata = ssh1pd_pkg::CSR_DATA_WIDTH'(debug_type_ff);
         ssh1pd_pkg::REG_IGNORE_TYPE: prdata = ssh1pd_pkg::CSR_DATA_WIDTH'(ignore_type_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff  <= LENGTH_WIDTH'(ssh1pd_pkg::MAX_LENGTH_RESET);
         debug_type_ff  <= 8'(ssh1pd_pkg::DEBUG_TYPE_RESET);
         ignore_type_ff <= 8'(ssh1pd_pkg::IGNORE_TYPE_RESET);
      end else begin
         max_length_ff  <= max_length_in;
         debug_type_ff  <= debug_type_in;
         ignore_type_ff <= ignore_type_in;
      end
   end

   // front end
   assign full   = op_full;
   assign accept = push && !op_full;

   ssh1pd_front #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .max_length (max_length_ff),
      .debug_type (debug_type_ff),
      .ignore_type(ignore_type_ff),
      .op_push    (op_push),
      .op         (op_wr),
      .stat       (front_stat)
   );

   ssh1pd_fifo #(
      .WIDTH(OPW),
      .DEPTH(QUEUE_DEPTH)
   ) u_op_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (op_push),
      .push_data(op_wr),
      .full     (op_full),
      .pop      (op_pop),
      .pop_data (op_rd),
      .empty    (op_empty)
   );

   // back end
   ssh1pd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .op_empty(op_empty),
      .op      (op_rd),
      .op_pop  (op_pop),
      .res_full(res_full),
      .res_push(res_push),
      .res     (res_wr)
   );

   ssh1pd_fifo #(
      .WIDTH(RSPW),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_push),
      .push_data(res_wr),
      .full     (res_full),
      .pop      (pop),
      .pop_data (res_rd),
      .empty    (empty)
   );

   assign rsp_out_byte      = res_rd.out_byte;
   assign rsp_byte_is_type  = res_rd.byte_is_type;
   assign rsp_end_of_packet = res_rd.end_of_packet;
   assign rsp_status        = res_rd.status;

   // a length error stops the front end on the next cycle
   `SSH1PD_ASSERT_NXT(a_err_halts, clock, reset, op_push && (op_wr.kind == ssh1pd_pkg::OP_ERR), front_stat.halted)
   // once halted, no further work leaves the front end
   `SSH1PD_ASSERT_NXT(a_halt_sticks, clock, reset, front_stat.halted, front_stat.halted && !op_push)
   `SSH1PD_ASSERT_IMP(a_end_item_clean, clock, reset, !empty && rsp_end_of_packet, (rsp_out_byte == 8'd0) && !rsp_byte_is_type)
   `SSH1PD_ASSERT_IMP(a_byte_item_good, clock, reset, !empty && !rsp_end_of_packet, rsp_status == ssh1pd_pkg::ST_GOOD)

endmodule
`default_nettype wire

// ----- src/ssh1pd_fifo.sv -----
// small register-based queue used between the stages
`default_nettype none
module ssh1pd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ssh1pd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- src/ssh1pd_front.sv -----
// front end: framing state machine, length check and byte classification
`default_nettype none
module ssh1pd_front #(
   parameter int LENGTH_WIDTH = ssh1pd_pkg::LENGTH_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [7:0]              rx_byte,
   input  wire logic [LENGTH_WIDTH-1:0] max_length,
   input  wire logic [7:0]              debug_type,
   input  wire logic [7:0]              ignore_type,
   output logic                         op_push,
   output ssh1pd_pkg::op_type           op,
   output ssh1pd_pkg::front_stat_type   stat
);

   logic [2:0]              phase_ff, phase_in;
   logic [31:0]             length_ff, length_in;
   logic [LENGTH_WIDTH-1:0] count_ff, count_in;
   logic [3:0]              pad_ff, pad_in;
   logic                    discard_ff, discard_in;
   logic                    halted_ff, halted_in;
   logic                    drop_type;

   assign stat.halted = halted_ff;
   assign stat.phase  = phase_ff;
   assign drop_type   = (rx_byte == debug_type) || (rx_byte == ignore_type);

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      pad_in     = pad_ff;
      discard_in = discard_ff;
      halted_in  = halted_ff;
      op_push    = 1'b0;
      op         = '0;
      op.data    = rx_byte;
      if (accept && !halted_ff) begin
         case (phase_ff)
            ssh1pd_pkg::PH_PAD: begin
               op_push = 1'b1;
               op.kind = ssh1pd_pkg::OP_CRC;
               pad_in  = pad_ff - 1'b1;
               if (pad_in == 4'd0) begin
                  phase_in = ssh1pd_pkg::PH_TYPE;
               end
            end
            ssh1pd_pkg::PH_TYPE: begin
               op_push    = 1'b1;
               op.kind    = ssh1pd_pkg::OP_CRC;
               op.emit    = !drop_type;
               op.is_type = 1'b1;
               discard_in = drop_type;
               count_in   = count_ff - 1'b1;
               phase_in   = (count_in == '0) ? ssh1pd_pkg::PH_CRC : ssh1pd_pkg::PH_DATA;
            end
            ssh1pd_pkg::PH_DATA: begin
               op_push  = 1'b1;
               op.kind  = ssh1pd_pkg::OP_CRC;
               op.emit  = !discard_ff;
               count_in = count_ff - 1'b1;
               if (count_in == '0) begin
                  phase_in = ssh1pd_pkg::PH_CRC;
               end
            end
            ssh1pd_pkg::PH_CRC: begin
               op_push  = 1'b1;
               op.kind  = ssh1pd_pkg::OP_CHK;
               op.drop  = discard_ff;
               count_in = count_ff + 1'b1;
               op.last  = (count_in == LENGTH_WIDTH'(ssh1pd_pkg::WORD_BYTES));
               if (op.last) begin
                  phase_in   = ssh1pd_pkg::PH_LEN;
                  count_in   = '0;
                  pad_in     = 4'd0;
                  discard_in = 1'b0;
               end
            end
            default: begin
               // length bytes, big-endian
               length_in = {length_ff[23:0], rx_byte};
               count_in  = count_ff + 1'b1;
               if (count_in == LENGTH_WIDTH'(ssh1pd_pkg::WORD_BYTES)) begin
                  if (length_in > 32'(max_length)) begin
                     op_push   = 1'b1;
                     op.kind   = ssh1pd_pkg::OP_ERR;
                     op.status = ssh1pd_pkg::ST_TOO_LONG;
                     halted_in = 1'b1;
                  end else if (length_in < 32'(ssh1pd_pkg::MIN_LENGTH)) begin
                     op_push   = 1'b1;
                     op.kind   = ssh1pd_pkg::OP_ERR;
                     op.status = ssh1pd_pkg::ST_TOO_SHORT;
                     halted_in = 1'b1;
                  end else begin
                     pad_in   = 4'(ssh1pd_pkg::PAD_BLOCK) - {1'b0, length_in[2:0]};
                     count_in = length_in[LENGTH_WIDTH-1:0]
                              - LENGTH_WIDTH'(ssh1pd_pkg::WORD_BYTES);
                     phase_in = ssh1pd_pkg::PH_PAD;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ssh1pd_pkg::PH_LEN;
         length_ff  <= '0;
         count_ff   <= '0;
         pad_ff     <= '0;
         discard_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         pad_ff     <= pad_in;
         discard_ff <= discard_in;
         halted_ff  <= halted_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/ssh1pd_back.sv -----
// back end: crc accumulation, crc compare and result formatting
`default_nettype none
module ssh1pd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                op_empty,
   input  wire ssh1pd_pkg::op_type  op,
   output logic                     op_pop,
   input  wire logic                res_full,
   output logic                     res_push,
   output ssh1pd_pkg::rsp_type      res
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic        bad;

   assign op_pop = !op_empty && !res_full;

   always_comb begin
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      res_push  = 1'b0;
      res       = '0;
      bad       = 1'b0;
      if (op_pop) begin
         case (op.kind)
            ssh1pd_pkg::OP_CRC: begin
               crc_in           = ssh1pd_pkg::crc_byte(crc_ff, op.data);
               res_push         = op.emit;
               res.out_byte     = op.data;
               res.byte_is_type = op.is_type;
            end
            ssh1pd_pkg::OP_CHK: begin
               rx_crc_in = {rx_crc_ff[23:0], op.data};
               if (op.last) begin
                  bad               = (rx_crc_in != crc_ff);
                  // a dropped packet only reports a bad crc
                  res_push          = !op.drop || bad;
                  res.end_of_packet = 1'b1;
                  res.status        = bad ? ssh1pd_pkg::ST_CRC_ERR : ssh1pd_pkg::ST_GOOD;
                  crc_in            = '0;
               end
            end
            ssh1pd_pkg::OP_ERR: begin
               res_push          = 1'b1;
               res.end_of_packet = 1'b1;
               res.status        = op.status;
            end
            default: begin
               res_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         rx_crc_ff <= '0;
      end else begin
         crc_ff    <= crc_in;
         rx_crc_ff <= rx_crc_in;
      end
   end

endmodule
`default_nettype wire

// ----- test/ssh1_packet_deframer_test.sv -----
// testbench for the ssh1 packet deframer: framed byte stream in, predicted result items checked
`timescale 1ns / 1ps
module ssh1_packet_deframer_test;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_BYTES    = 220;
   localparam int LW             = ssh1pd_pkg::LENGTH_WIDTH_DEF;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef enum int {END_TOO_LONG, END_TOO_SHORT, END_SMALL_MAX} halt_case_type;

   // software copy of the deframer: framing state, crc and registers
   class deframe_tracker_type;
      logic [LW-1:0]       max_len;
      logic [7:0]          dbg_code;
      logic [7:0]          ign_code;
      logic [2:0]          phase;
      logic [31:0]         len_word;
      logic [LW-1:0]       count;
      logic [3:0]          pad_left;
      logic [31:0]         crc_calc;
      logic [31:0]         crc_seen;
      bit                  drop_pkt;
      bit                  stopped;
      ssh1pd_pkg::rsp_type due_items[$];

      function new();
         max_len  = LW'(ssh1pd_pkg::MAX_LENGTH_RESET);
         dbg_code = 8'(ssh1pd_pkg::DEBUG_TYPE_RESET);
         ign_code = 8'(ssh1pd_pkg::IGNORE_TYPE_RESET);
         stopped  = 0;
         restart();
      endfunction

      function void restart();
         phase    = ssh1pd_pkg::PH_LEN;
         len_word = '0;
         count    = '0;
         pad_left = '0;
         crc_calc = '0;
         crc_seen = '0;
         drop_pkt = 0;
      endfunction

      function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
         logic [31:0] r;
         r = c ^ {24'd0, b};
         for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
         end
         return r;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            ssh1pd_pkg::REG_MAX_LENGTH:  max_len  = v[LW-1:0];
            ssh1pd_pkg::REG_DEBUG_TYPE:  dbg_code = v[7:0];
            ssh1pd_pkg::REG_IGNORE_TYPE: ign_code = v[7:0];
            default: ;
         endcase
      endfunction

      function void add_item(logic [7:0] b, logic is_type, logic eop, logic [1:0] st);
         ssh1pd_pkg::rsp_type r;
         r.out_byte      = b;
         r.byte_is_type  = is_type;
         r.end_of_packet = eop;
         r.status        = st;
         due_items.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b);
         bit bad;
         bit was_dropped;
         if (stopped) return;
         case (phase)
            ssh1pd_pkg::PH_PAD: begin
               crc_calc = crc_step(crc_calc, b);
               pad_left = pad_left - 4'd1;
               if (pad_left == 0) phase = ssh1pd_pkg::PH_TYPE;
            end
            ssh1pd_pkg::PH_TYPE: begin
               crc_calc = crc_step(crc_calc, b);
               drop_pkt = (b == dbg_code) || (b == ign_code);
               count    = count - 1'b1;
               phase    = (count == 0) ? ssh1pd_pkg::PH_CRC : ssh1pd_pkg::PH_DATA;
               if (!drop_pkt) add_item(b, 1'b1, 1'b0, ssh1pd_pkg::ST_GOOD);
            end
            ssh1pd_pkg::PH_DATA: begin
               crc_calc = crc_step(crc_calc, b);
               count    = count - 1'b1;
               if (count == 0) phase = ssh1pd_pkg::PH_CRC;
               if (!drop_pkt) add_item(b, 1'b0, 1'b0, ssh1pd_pkg::ST_GOOD);
            end
            ssh1pd_pkg::PH_CRC: begin
               crc_seen = {crc_seen[23:0], b};
               count    = count + 1'b1;
               if (count < ssh1pd_pkg::WORD_BYTES) return;
               bad         = (crc_seen != crc_calc);
               was_dropped = drop_pkt;
               restart();
               if (was_dropped && !bad) return;
               add_item(8'd0, 1'b0, 1'b1,
                        bad ? ssh1pd_pkg::ST_CRC_ERR : ssh1pd_pkg::ST_GOOD);
            end
            default: begin
               len_word = {len_word[23:0], b};
               count    = count + 1'b1;
               if (count < ssh1pd_pkg::WORD_BYTES) return;
               if (len_word > 32'(max_len)) begin
                  stopped = 1;
                  add_item(8'd0, 1'b0, 1'b1, ssh1pd_pkg::ST_TOO_LONG);
                  return;
               end
               if (len_word < ssh1pd_pkg::MIN_LENGTH) begin
                  stopped = 1;
                  add_item(8'd0, 1'b0, 1'b1, ssh1pd_pkg::ST_TOO_SHORT);
                  return;
               end
               pad_left = 4'(ssh1pd_pkg::PAD_BLOCK) - {1'b0, len_word[2:0]};
               count    = LW'(len_word - ssh1pd_pkg::WORD_BYTES);
               crc_calc = '0;
               crc_seen = '0;
               phase    = ssh1pd_pkg::PH_PAD;
            end
         endcase
      endfunction

      function string check_item(ssh1pd_pkg::rsp_type got);
         ssh1pd_pkg::rsp_type want;
         string               msg;
         if (due_items.size() == 0) begin
            return $sformatf("result item with nothing expected: byte %02h type %0b end %0b st %0d",
                             got.out_byte, got.byte_is_type, got.end_of_packet, got.status);
         end
         want = due_items.pop_front();
         msg  = "";
         if (got.out_byte !== want.out_byte)
            msg = {msg, $sformatf(" out_byte %02h/%02h", got.out_byte, want.out_byte)};
         if (got.byte_is_type !== want.byte_is_type)
            msg = {msg, $sformatf(" byte_is_type %0b/%0b", got.byte_is_type, want.byte_is_type)};
         if (got.end_of_packet !== want.end_of_packet)
            msg = {msg, $sformatf(" end_of_packet %0b/%0b", got.end_of_packet, want.end_of_packet)};
         if (got.status !== want.status)
            msg = {msg, $sformatf(" status %0d/%0d", got.status, want.status)};
         if (msg != "") msg = {"result item mismatch (got/want):", msg};
         return msg;
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [7:0] req_rx_byte = 8'd0;
   logic empty;
   logic pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_byte_is_type;
   logic rsp_end_of_packet;
   logic [1:0] rsp_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ssh1pd_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [ssh1pd_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [ssh1pd_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic pready;

   deframe_tracker_type board;
   int error_count = 0;
   int bytes_sent = 0;
   int gap_pct = 0;
   bit calm_end = 0;
   int pop_wait = 0;
   int pop_run = 0;

   ssh1_packet_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_rx_byte       (req_rx_byte),
      .empty             (empty),
      .pop               (pop),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_is_type  (rsp_byte_is_type),
      .rsp_end_of_packet (rsp_end_of_packet),
      .rsp_status        (rsp_status),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t: %s", $time, what);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      board.write_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [1:0] idx, output logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_regs();
      logic [31:0] got;
      csr_read(ssh1pd_pkg::REG_MAX_LENGTH, got);
      if (got !== 32'(board.max_len))
         report_mismatch($sformatf("max_length reads %0h, want %0h", got, board.max_len));
      csr_read(ssh1pd_pkg::REG_DEBUG_TYPE, got);
      if (got !== 32'(board.dbg_code))
         report_mismatch($sformatf("debug_type reads %0h, want %0h", got, board.dbg_code));
      csr_read(ssh1pd_pkg::REG_IGNORE_TYPE, got);
      if (got !== 32'(board.ign_code))
         report_mismatch($sformatf("ignore_type reads %0h, want %0h", got, board.ign_code));
   endtask

   // push stays high from one item to the next; only a gap or wait_drained lowers it
   task automatic send_byte(input logic [7:0] b);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      push        <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (full !== 1'b0);
      board.take_byte(b);
      bytes_sent++;
   endtask

   task automatic send_packet(input int unsigned len, input logic [7:0] kind, input bit corrupt);
      logic [31:0] lw;
      logic [31:0] crc;
      logic [7:0]  b;
      lw      = len;
      crc     = '0;
      gap_pct = calm_end ? 0 : (($urandom_range(0, 3) == 0) ? 0 : 15);
      for (int i = 3; i >= 0; i--) send_byte(lw[8*i +: 8]);
      repeat (ssh1pd_pkg::PAD_BLOCK - (len % ssh1pd_pkg::PAD_BLOCK)) begin
         b   = 8'($urandom_range(0, 255));
         crc = board.crc_step(crc, b);
         send_byte(b);
      end
      crc = board.crc_step(crc, kind);
      send_byte(kind);
      repeat (len - ssh1pd_pkg::MIN_LENGTH) begin
         if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         else b = 8'($urandom_range(0, 255));
         crc = board.crc_step(crc, b);
         send_byte(b);
      end
      if (corrupt) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 3; i >= 0; i--) send_byte(crc[8*i +: 8]);
   endtask

   // hold the sender until every predicted item has been popped
   task automatic wait_drained();
      push <= 1'b0;
      while (board.due_items.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 9))
         0:       return board.dbg_code;
         1:       return board.ign_code;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   always @(posedge clock) begin : rsp_side
      ssh1pd_pkg::rsp_type got;
      string               msg;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && empty === 1'b0) begin
            got.out_byte      = rsp_out_byte;
            got.byte_is_type  = rsp_byte_is_type;
            got.end_of_packet = rsp_end_of_packet;
            got.status        = rsp_status;
            msg = board.check_item(got);
            if (msg != "") report_mismatch(msg);
         end
         if (calm_end) begin
            pop <= 1'b1;
         end else if (pop_wait > 0) begin
            pop_wait--;
            pop <= 1'b0;
         end else if (pop_run > 0) begin
            pop_run--;
            pop <= 1'b1;
         end else begin
            pop_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            pop_run  = (pop_wait == 0) ? $urandom_range(40, 150) : $urandom_range(1, 25);
            pop <= (pop_wait == 0);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((push && full === 1'b0) || (pop && empty === 1'b0)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("ssh1_packet_deframer verification failed");
      $finish;
   end

   initial begin : main_flow
      logic [31:0]   m;
      logic [31:0]   len;
      logic [7:0]    d;
      logic [7:0]    g;
      int unsigned   cap;
      int            target;
      halt_case_type halt_case;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_regs();

      // a write past the register list changes nothing
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);
      check_regs();
      // debug packet with good crc vanishes; ignore packet with bad crc leaves an end item
      send_packet(ssh1pd_pkg::MIN_LENGTH, board.dbg_code, 1'b0);
      send_packet(7, board.ign_code, 1'b1);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin
               m = ssh1pd_pkg::MIN_LENGTH;
               d = 8'h00;
               g = 8'hFF;
            end
            1: begin
               m = ssh1pd_pkg::MAX_LENGTH_RESET;
               d = 8'hFF;
               g = 8'h00;
            end
            2: begin
               m = $urandom_range(ssh1pd_pkg::MIN_LENGTH, 400);
               d = 8'($urandom_range(0, 255));
               g = d;
            end
            default: begin
               m = $urandom_range(0, 1)
                   ? $urandom_range(ssh1pd_pkg::MIN_LENGTH, 600)
                   : $urandom_range(ssh1pd_pkg::MIN_LENGTH, ssh1pd_pkg::MAX_LENGTH_RESET);
               d = 8'($urandom_range(0, 255));
               g = 8'($urandom_range(0, 255));
            end
         endcase
         calm_end = (p == 7);
         csr_write(ssh1pd_pkg::REG_MAX_LENGTH, m);
         csr_write(ssh1pd_pkg::REG_DEBUG_TYPE, {24'd0, d});
         csr_write(ssh1pd_pkg::REG_IGNORE_TYPE, {24'd0, g});
         check_regs();
         target = bytes_sent + PHASE_BYTES;
         // a packet of exactly the largest accepted length
         if (p == 2) send_packet(board.max_len, pick_type(), 1'b0);
         while (bytes_sent < target) begin
            cap = (board.max_len < 40) ? board.max_len : 40;
            if ($urandom_range(0, 39) == 0) cap = (board.max_len < 600) ? board.max_len : 600;
            send_packet($urandom_range(ssh1pd_pkg::MIN_LENGTH, cap), pick_type(),
                        $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 19) == 0) wait_drained();
         end
         wait_drained();
      end

      // a length error halts the block for good, so only one can close the run
      halt_case = halt_case_type'($urandom_range(0, 2));
      case (halt_case)
         END_TOO_LONG: begin
            if ($urandom_range(0, 1)) len = 32'(board.max_len) + 32'd1;
            else len = {8'($urandom_range(1, 255)), 24'($urandom)};
         end
         END_TOO_SHORT: begin
            len = $urandom_range(0, ssh1pd_pkg::MIN_LENGTH - 1);
         end
         default: begin
            csr_write(ssh1pd_pkg::REG_MAX_LENGTH,
                      $urandom_range(0, ssh1pd_pkg::MIN_LENGTH - 1));
            check_regs();
            len = $urandom_range(ssh1pd_pkg::MIN_LENGTH, 40);
         end
      endcase
      for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      // halted: these are swallowed
      repeat (20) send_byte(8'($urandom_range(0, 255)));
      wait_drained();

      if (error_count == 0) begin
         $display("ssh1_packet_deframer verification clean");
      end else begin
         $display("ssh1_packet_deframer verification failed");
      end
      $finish;
   end
endmodule
